FILE: rtl/core/gext_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gext_pkg
// Shared constants and types for the gradient extrema tracker.
// ============================================================================
package gext_pkg;

    // Fixed field widths of the ports.
    localparam int PIX_IN_W = 16;   // input pixel port
    localparam int OUT_W    = 17;   // difference result ports
    localparam int FW_W     = 11;   // frame_width register
    localparam int FH_W     = 16;   // frame_height register

    // Configuration port.
    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd1024;

    // Defaults for the top level parameters.
    localparam int DEF_PIXEL_BITS = 16;
    localparam int DEF_MAX_WIDTH  = 1024;

    // Classification of one item, produced by the front and used by the back.
    typedef struct packed {
        logic is_h;   // column 2 or more: horizontal difference applies
        logic is_v;   // row 2 or more: vertical difference applies
        logic last;   // last pixel of the frame
    } item_flags_t;

endpackage

FILE: rtl/core/gext_front.sv
`timescale 1ns / 1ps
// ============================================================================
// gext_front
// Accepts pixels, tracks the raster position and classifies each item.
// ============================================================================
module gext_front #(
    parameter int PIXEL_BITS = gext_pkg::DEF_PIXEL_BITS,
    parameter int MAX_WIDTH  = gext_pkg::DEF_MAX_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        restart,
    input  logic [gext_pkg::FW_W-1:0]   frame_width,
    input  logic [gext_pkg::FH_W-1:0]   frame_height,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [gext_pkg::PIX_IN_W-1:0] s_pixel,
    output logic                        item_valid,
    input  logic                        item_ready,
    output logic [((PIXEL_BITS < gext_pkg::PIX_IN_W) ? PIXEL_BITS : gext_pkg::PIX_IN_W)-1:0]
                                        item_pix,
    output logic [((PIXEL_BITS < gext_pkg::PIX_IN_W) ? PIXEL_BITS : gext_pkg::PIX_IN_W)-1:0]
                                        item_back_two,
    output logic [$clog2(2 * MAX_WIDTH)-1:0] item_slot,
    output gext_pkg::item_flags_t       item_flags
);

    localparam int PIX_W  = (PIXEL_BITS < gext_pkg::PIX_IN_W) ? PIXEL_BITS : gext_pkg::PIX_IN_W;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ADDR_W = $clog2(2 * MAX_WIDTH);
    localparam int CMP_W  = (COL_W + 1 > gext_pkg::FW_W + 1) ? COL_W + 1 : gext_pkg::FW_W + 1;
    localparam int ROW_W  = gext_pkg::FH_W;

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PIX_W-1:0] back_one_reg;
    logic [PIX_W-1:0] back_two_reg;

    logic [CMP_W-1:0] w_nz;
    logic [CMP_W-1:0] w_eff;
    logic [ROW_W:0]   h_eff;
    logic             col_end;
    logic             row_end;
    logic             accept;

    // A zero width or height counts as one; width saturates at MAX_WIDTH, the size of one line buffer.
    always_comb begin
        w_nz  = (frame_width == '0) ? CMP_W'(1) : CMP_W'(frame_width);
        w_eff = (w_nz > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_nz;
        h_eff = (frame_height == '0) ? (ROW_W + 1)'(1) : (ROW_W + 1)'(frame_height);
        col_end = (CMP_W'(col_reg) + CMP_W'(1)) >= w_eff;
        row_end = ((ROW_W + 1)'(row_reg) + (ROW_W + 1)'(1)) >= h_eff;
    end

    assign s_ready    = item_ready;
    assign item_valid = s_valid;
    assign accept     = s_valid && item_ready;

    assign item_pix        = s_pixel[PIX_W-1:0];
    assign item_back_two   = back_two_reg;
    assign item_slot       = row_reg[0] ? (ADDR_W'(MAX_WIDTH) + ADDR_W'(col_reg))
                                        : ADDR_W'(col_reg);
    assign item_flags.is_h = (col_reg >= COL_W'(2));
    assign item_flags.is_v = (row_reg >= ROW_W'(2));
    assign item_flags.last = col_end && row_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (restart) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            if (col_end) begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // The last two pixels; only used once the column is 2 or more.
    always_ff @(posedge aclk) begin
        if (accept) begin
            back_two_reg <= back_one_reg;
            back_one_reg <= s_pixel[PIX_W-1:0];
        end
    end

endmodule

FILE: rtl/core/gext_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// gext_queue
// Two-entry queue that decouples the front from the back.
// ============================================================================
module gext_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue push lost");
`endif

endmodule

FILE: rtl/core/gext_back.sv
`timescale 1ns / 1ps
// ============================================================================
// gext_back
// Line store access, difference computation, extrema tracking and result
// register.
// ============================================================================
module gext_back #(
    parameter int PIXEL_BITS = gext_pkg::DEF_PIXEL_BITS,
    parameter int MAX_WIDTH  = gext_pkg::DEF_MAX_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              restart,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [((PIXEL_BITS < gext_pkg::PIX_IN_W) ? PIXEL_BITS : gext_pkg::PIX_IN_W)-1:0]
                                              in_pix,
    input  logic [((PIXEL_BITS < gext_pkg::PIX_IN_W) ? PIXEL_BITS : gext_pkg::PIX_IN_W)-1:0]
                                              in_back_two,
    input  logic [$clog2(2 * MAX_WIDTH)-1:0]  in_slot,
    input  gext_pkg::item_flags_t             in_flags,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [gext_pkg::OUT_W-1:0] m_horiz_max,
    output logic signed [gext_pkg::OUT_W-1:0] m_horiz_min,
    output logic signed [gext_pkg::OUT_W-1:0] m_vert_max,
    output logic signed [gext_pkg::OUT_W-1:0] m_vert_min,
    output logic                              m_horiz_found,
    output logic                              m_vert_found
);

    localparam int PIX_W  = (PIXEL_BITS < gext_pkg::PIX_IN_W) ? PIXEL_BITS : gext_pkg::PIX_IN_W;
    localparam int DIFF_W = PIX_W + 1;
    localparam int OUT_W  = gext_pkg::OUT_W;
    localparam int DEPTH  = 2 * MAX_WIDTH;

    // Two line buffers, one per row parity.
    logic [PIX_W-1:0] line_mem [DEPTH];

    // Stage one: item plus the pixel two rows up.
    logic                  s1_valid_reg;
    logic [PIX_W-1:0]      s1_pix_reg;
    logic [PIX_W-1:0]      s1_back_two_reg;
    logic [PIX_W-1:0]      s1_up_reg;
    gext_pkg::item_flags_t s1_flags_reg;

    // Running extrema; values are meaningful only while their found flag is set.
    logic signed [DIFF_W-1:0] hmax_reg, hmin_reg, vmax_reg, vmin_reg;
    logic                     hfound_reg, vfound_reg;

    logic signed [DIFF_W-1:0] hmax_next, hmin_next, vmax_next, vmin_next;
    logic                     hfound_next, vfound_next;
    logic signed [DIFF_W-1:0] h_diff, v_diff;

    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_hmax_reg, m_hmin_reg, m_vmax_reg, m_vmin_reg;
    logic                 m_hfound_reg, m_vfound_reg;

    logic pop;
    logic adv;

    // Only a frame's last item needs room in the result register.
    assign adv      = s1_valid_reg && (!s1_flags_reg.last || !m_valid_reg || m_ready);
    assign in_ready = !s1_valid_reg || adv;
    assign pop      = in_valid && in_ready;

    // Read before write: the slot still holds the pixel from two rows up.
    always_ff @(posedge aclk) begin
        if (pop) begin
            line_mem[in_slot] <= in_pix;
            s1_up_reg         <= line_mem[in_slot];
            s1_pix_reg        <= in_pix;
            s1_back_two_reg   <= in_back_two;
            s1_flags_reg      <= in_flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (pop) begin
            s1_valid_reg <= 1'b1;
        end else if (adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        h_diff = DIFF_W'(s1_pix_reg) - DIFF_W'(s1_back_two_reg);
        v_diff = DIFF_W'(s1_pix_reg) - DIFF_W'(s1_up_reg);

        hmax_next   = hmax_reg;
        hmin_next   = hmin_reg;
        vmax_next   = vmax_reg;
        vmin_next   = vmin_reg;
        hfound_next = hfound_reg;
        vfound_next = vfound_reg;

        if (s1_flags_reg.is_h) begin
            if (!hfound_reg || h_diff > hmax_reg) begin
                hmax_next = h_diff;
            end
            if (!hfound_reg || h_diff < hmin_reg) begin
                hmin_next = h_diff;
            end
            hfound_next = 1'b1;
        end
        if (s1_flags_reg.is_v) begin
            if (!vfound_reg || v_diff > vmax_reg) begin
                vmax_next = v_diff;
            end
            if (!vfound_reg || v_diff < vmin_reg) begin
                vmin_next = v_diff;
            end
            vfound_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hfound_reg <= 1'b0;
            vfound_reg <= 1'b0;
        end else if (restart) begin
            hfound_reg <= 1'b0;
            vfound_reg <= 1'b0;
        end else if (adv) begin
            hfound_reg <= hfound_next && !s1_flags_reg.last;
            vfound_reg <= vfound_next && !s1_flags_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hmax_reg <= hmax_next;
            hmin_reg <= hmin_next;
            vmax_reg <= vmax_next;
            vmin_reg <= vmin_next;
        end
    end

    // Result register: extrema with no difference seen report as zero.
    always_ff @(posedge aclk) begin
        if (adv && s1_flags_reg.last) begin
            m_hmax_reg   <= hfound_next ? OUT_W'($unsigned(hmax_next)) : '0;
            m_hmin_reg   <= hfound_next ? OUT_W'($unsigned(hmin_next)) : '0;
            m_vmax_reg   <= vfound_next ? OUT_W'($unsigned(vmax_next)) : '0;
            m_vmin_reg   <= vfound_next ? OUT_W'($unsigned(vmin_next)) : '0;
            m_hfound_reg <= hfound_next;
            m_vfound_reg <= vfound_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && s1_flags_reg.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_horiz_max   = m_hmax_reg;
    assign m_horiz_min   = m_hmin_reg;
    assign m_vert_max    = m_vmax_reg;
    assign m_vert_min    = m_vmin_reg;
    assign m_horiz_found = m_hfound_reg;
    assign m_vert_found  = m_vfound_reg;

`ifndef ASSERT_OFF
    a_h_order: assert property (@(posedge aclk) disable iff (!aresetn)
        hfound_reg |-> (hmin_reg <= hmax_reg))
        else $error("horizontal minimum above maximum");

    a_v_order: assert property (@(posedge aclk) disable iff (!aresetn)
        vfound_reg |-> (vmin_reg <= vmax_reg))
        else $error("vertical minimum above maximum");

    a_last_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_flags_reg.last && m_valid_reg && !m_ready)
        |=> (s1_valid_reg && s1_flags_reg.last))
        else $error("frame result dropped while result register full");

    a_cleared_after_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s1_flags_reg.last) |=> (!hfound_reg && !vfound_reg && m_valid_reg))
        else $error("tracking not cleared at end of frame");
`endif

endmodule

FILE: rtl/core/gradient_extrema_tracker_core.sv
`timescale 1ns / 1ps
// ============================================================================
// gradient_extrema_tracker_core
// Central-difference gradient extrema over a raster-order pixel stream.
// ============================================================================
//
// Usage:
//   Pixels arrive on the s_ channel (s_valid / s_ready / s_pixel) in raster
//   order. The frame size is set through the APB port: frame_width at 0x0,
//   frame_height at 0x4. Any register write restarts the frame; write only
//   while no item is in flight.
//   After the last pixel of a frame one result item leaves on the m_ channel
//   carrying the largest and smallest horizontal and vertical differences and
//   two found flags; extrema without a found flag read as zero.
//   Throughput is one pixel per clock while s_ready is high. The result of
//   a frame passes from its last pixel through the queue, whose output
//   addresses the line store, and then through the stage that holds the
//   line store read and updates the extrema into the result
//   register. A two-entry queue separates the pixel intake from that back
//   end, so intake keeps running while a result waits on a stalled m_ready;
//   only a following frame's last pixel waits for the result to be taken,
//   and intake stalls once the two queue entries behind it are full.
//   Reset sets the frame to 1024 x 1024 and clears position and tracking.
//   The line store is not cleared; every entry is written before its read value is used.
//
module gradient_extrema_tracker_core #(
    parameter int PIXEL_BITS = gext_pkg::DEF_PIXEL_BITS,
    parameter int MAX_WIDTH  = gext_pkg::DEF_MAX_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // APB configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gext_pkg::PADDR_W-1:0]        paddr,
    input  logic [gext_pkg::APB_DW-1:0]         pwdata,
    output logic [gext_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,

    // Pixel input channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gext_pkg::PIX_IN_W-1:0]       s_pixel,

    // Result channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [gext_pkg::OUT_W-1:0]   m_horiz_max,
    output logic signed [gext_pkg::OUT_W-1:0]   m_horiz_min,
    output logic signed [gext_pkg::OUT_W-1:0]   m_vert_max,
    output logic signed [gext_pkg::OUT_W-1:0]   m_vert_min,
    output logic                                m_horiz_found,
    output logic                                m_vert_found
);

    localparam int PIX_W  = (PIXEL_BITS < gext_pkg::PIX_IN_W) ? PIXEL_BITS : gext_pkg::PIX_IN_W;
    localparam int ADDR_W = $clog2(2 * MAX_WIDTH);
    localparam int FLG_W  = $bits(gext_pkg::item_flags_t);
    localparam int Q_W    = FLG_W + ADDR_W + 2 * PIX_W;

    // Configuration registers.
    logic [gext_pkg::FW_W-1:0]      frame_width_reg;
    logic [gext_pkg::FH_W-1:0]      frame_height_reg;
    logic [gext_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_write;

    // Front to queue.
    logic                  f_valid, f_ready;
    logic [PIX_W-1:0]      f_pix, f_back_two;
    logic [ADDR_W-1:0]     f_slot;
    gext_pkg::item_flags_t f_flags;

    // Queue to back.
    logic                  b_valid, b_ready;
    logic [Q_W-1:0]        q_in, q_out;
    logic [PIX_W-1:0]      b_pix, b_back_two;
    logic [ADDR_W-1:0]     b_slot;
    gext_pkg::item_flags_t b_flags;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[gext_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= gext_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= gext_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_write) begin
            case (reg_idx)
                gext_pkg::REG_FRAME_WIDTH: begin
                    frame_width_reg <= pwdata[gext_pkg::FW_W-1:0];
                end
                gext_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_reg <= pwdata[gext_pkg::FH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            gext_pkg::REG_FRAME_WIDTH:  prdata = gext_pkg::APB_DW'(frame_width_reg);
            gext_pkg::REG_FRAME_HEIGHT: prdata = gext_pkg::APB_DW'(frame_height_reg);
            default:                    prdata = '0;
        endcase
    end

    // Front: raster position and per-item classification.
    gext_front #(
        .PIXEL_BITS (PIXEL_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .restart       (cfg_write),
        .frame_width   (frame_width_reg),
        .frame_height  (frame_height_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .item_valid    (f_valid),
        .item_ready    (f_ready),
        .item_pix      (f_pix),
        .item_back_two (f_back_two),
        .item_slot     (f_slot),
        .item_flags    (f_flags)
    );

    assign q_in = {f_flags, f_slot, f_back_two, f_pix};

    gext_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (q_out)
    );

    assign {b_flags, b_slot, b_back_two, b_pix} = q_out;

    // Back: line store, differences, extrema and the result register.
    gext_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .restart       (cfg_write),
        .in_valid      (b_valid),
        .in_ready      (b_ready),
        .in_pix        (b_pix),
        .in_back_two   (b_back_two),
        .in_slot       (b_slot),
        .in_flags      (b_flags),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_horiz_max   (m_horiz_max),
        .m_horiz_min   (m_horiz_min),
        .m_vert_max    (m_vert_max),
        .m_vert_min    (m_vert_min),
        .m_horiz_found (m_horiz_found),
        .m_vert_found  (m_vert_found)
    );

endmodule
